>>> rtl/ppvs_pkg.sv
`timescale 1ns / 1ps
// Package for the pneumatic piston valve sequencer: mode and valve codes,
// controller states, item, result, command and status structs, widths.
// No dependencies.
package ppvs_pkg;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int LEN_WIDTH      = 15;
   localparam int POS_WIDTH      = 16;
   localparam int PCT_WIDTH      = 7;
   localparam int PROD_WIDTH     = 22;
   localparam int DIV_STEPS      = 7;
   localparam int DIV_CNT_WIDTH  = $clog2(DIV_STEPS);

   localparam logic [PCT_WIDTH-1:0] PCT_FULL = 7'd100;

   localparam logic [1:0] REG_PRESET_LENGTH     = 2'd0;
   localparam logic [1:0] REG_PRESET_INVERT     = 2'd1;
   localparam logic [1:0] REG_IGNORE_INTERLOCKS = 2'd2;
   localparam logic [1:0] REG_DUAL_VALVES       = 2'd3;

   typedef enum logic [1:0] {
      MODE_INIT = 2'd0,
      MODE_IDLE = 2'd1,
      MODE_DEAD = 2'd2,
      MODE_MOVE = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      VALVE_CLOSE     = 3'd0,
      VALVE_FRONT     = 3'd1,
      VALVE_BACK      = 3'd2,
      VALVE_BACK_OUT  = 3'd3,
      VALVE_FRONT_OUT = 3'd4,
      VALVE_HOLD      = 3'd5
   } valve_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DELTA,
      ST_LEARN,
      ST_CLAMP,
      ST_MUL,
      ST_DIV,
      ST_UPDATE
   } ctrl_state_type;

   typedef struct packed {
      logic signed [7:0] step_delta;
      logic              back_stop;
      logic              front_stop;
      logic              throttle_on;
      logic              brake_on;
      logic              shift_on;
      logic [6:0]        fill_percent;
      logic [7:0]        dead_ms;
      logic [31:0]       now_ms;
   } item_type;

   typedef struct packed {
      valve_type               valve_cmd;
      logic [PCT_WIDTH-1:0]    position_pct;
      mode_type                mode;
      logic                    moving_front;
      logic                    dual_out;
   } result_type;

   typedef struct packed {
      logic load_item;
      logic apply_delta;
      logic learn_step;
      logic clamp_step;
      logic mul_step;
      logic div_step;
      logic update_step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_last;
      logic out_free;
   } ctrl_status_type;

   typedef struct packed {
      logic                      write;
      logic [1:0]                index;
      logic [CSR_DATA_WIDTH-1:0] wdata;
   } csr_write_type;

endpackage

>>> rtl/ppvs_req_if.sv
`timescale 1ns / 1ps
// Input channel of the valve sequencer: one control tick per transfer.
// No dependencies.
interface ppvs_req_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] step_delta;
   logic              back_stop;
   logic              front_stop;
   logic              throttle_on;
   logic              brake_on;
   logic              shift_on;
   logic [6:0]        fill_percent;
   logic [7:0]        dead_ms;
   logic [31:0]       now_ms;

   modport source (
      output valid, step_delta, back_stop, front_stop, throttle_on, brake_on,
             shift_on, fill_percent, dead_ms, now_ms,
      input  ready
   );

   modport sink (
      input  valid, step_delta, back_stop, front_stop, throttle_on, brake_on,
             shift_on, fill_percent, dead_ms, now_ms,
      output ready
   );
endinterface

>>> rtl/ppvs_rsp_if.sv
`timescale 1ns / 1ps
// Result channel of the valve sequencer: one valve command per transfer.
// No dependencies.
interface ppvs_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] valve_cmd;
   logic [6:0] position_pct;
   logic [1:0] mode;
   logic       moving_front;
   logic       dual_out;

   modport source (
      output valid, valve_cmd, position_pct, mode, moving_front, dual_out,
      input  ready
   );

   modport sink (
      input  valid, valve_cmd, position_pct, mode, moving_front, dual_out,
      output ready
   );
endinterface

>>> rtl/ppvs_controller.sv
`timescale 1ns / 1ps
// Sequencing state machine of the valve sequencer.
// Depends on ppvs_pkg; drives the datapath through ctrl_cmd_type.
module ppvs_controller
   import ppvs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_DELTA;
            end
         end
         ST_DELTA: begin
            cmd.apply_delta = 1'b1;
            state_in        = ST_LEARN;
         end
         ST_LEARN: begin
            cmd.learn_step = 1'b1;
            state_in       = ST_CLAMP;
         end
         ST_CLAMP: begin
            cmd.clamp_step = 1'b1;
            state_in       = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (status.out_free) begin
               cmd.update_step = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/ppvs_datapath.sv
`timescale 1ns / 1ps
// Datapath of the valve sequencer: piston state, learning, clamping,
// percent multiply and restoring divider, stroke update, output register.
// Depends on ppvs_pkg.
module ppvs_datapath
   import ppvs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  ctrl_cmd_type              cmd,
   output ctrl_status_type           status,
   input  item_type                  req_item,
   input  csr_write_type             csr_wr,
   input  logic [1:0]                csr_rindex,
   output logic [CSR_DATA_WIDTH-1:0] csr_rdata,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output result_type                rsp_result
);

   // configuration
   logic [LEN_WIDTH-1:0] preset_len_ff, preset_len_in;
   logic                 preset_inv_ff, preset_inv_in;
   logic                 ignore_ff, ignore_in;
   logic                 dual_ff, dual_in;

   // piston state
   mode_type             mode_ff, mode_in;
   mode_type             prior_ff, prior_in;
   logic                 dir_ff, dir_in;
   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   logic [LEN_WIDTH-1:0] len_ff, len_in;
   logic                 inv_ff, inv_in;
   logic [PCT_WIDTH-1:0] start_ff, start_in;
   logic [31:0]          deadline_ff, deadline_in;

   // per-item work registers
   item_type                 item_ff, item_in;
   logic                     init_path_ff, init_path_in;
   logic [LEN_WIDTH-1:0]     e_ff, e_in;
   logic                     zero_ff, zero_in;
   logic                     full_ff, full_in;
   logic [PROD_WIDTH-1:0]    rem_ff, rem_in;
   logic [PCT_WIDTH-1:0]     quo_ff, quo_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type res_ff, res_in;

   // delta
   logic signed [8:0]    delta_wide, delta_adj;
   logic [POS_WIDTH-1:0] pos_step;

   assign delta_wide = {item_ff.step_delta[7], item_ff.step_delta};
   assign delta_adj  = inv_ff ? (9'sd0 - delta_wide) : delta_wide;
   assign pos_step   = pos_ff + {{(POS_WIDTH-9){delta_adj[8]}}, delta_adj};

   logic hold;
   assign hold = (item_ff.fill_percent == '0);

   // learning while uninitialized
   logic [POS_WIDTH-1:0] lrn_pos;
   logic                 lrn_dir;
   mode_type             lrn_mode;
   logic [LEN_WIDTH-1:0] lrn_len;
   logic                 lrn_inv;
   logic                 len_nz;
   logic [POS_WIDTH-1:0] lrn_mag;

   assign len_nz = (len_ff != '0);

   always_comb begin
      lrn_pos  = pos_ff;
      lrn_dir  = dir_ff;
      lrn_mode = mode_ff;
      lrn_len  = len_ff;
      lrn_inv  = inv_ff;
      lrn_mag  = pos_ff;
      if (item_ff.back_stop) begin
         lrn_pos = '0;
         if (len_nz) begin
            lrn_dir  = 1'b0;
            lrn_mode = MODE_IDLE;
         end else begin
            lrn_dir = 1'b1;
         end
      end
      if (item_ff.front_stop) begin
         if (len_nz) begin
            lrn_pos  = POS_WIDTH'(len_ff);
            lrn_dir  = 1'b1;
            lrn_mode = MODE_IDLE;
         end else if (lrn_dir) begin
            lrn_mag = lrn_pos;
            if (lrn_pos[POS_WIDTH-1]) begin
               lrn_inv = ~inv_ff;
               lrn_mag = '0 - lrn_pos;
               if (lrn_mag[POS_WIDTH-1]) begin
                  lrn_mag = {1'b0, {(POS_WIDTH-1){1'b1}}};
               end
            end
            lrn_pos  = lrn_mag;
            lrn_len  = lrn_mag[LEN_WIDTH-1:0];
            lrn_mode = MODE_IDLE;
         end
      end
      if (len_nz) begin
         if (lrn_mode == MODE_INIT) begin
            lrn_pos = POS_WIDTH'(len_ff >> 1);
            lrn_dir = 1'b0;
         end
         lrn_mode = MODE_IDLE;
      end
   end

   // clamp to endstops and length
   logic signed [POS_WIDTH-1:0] pos_s, len_s, clamp_e, pct_src;

   assign pos_s = $signed(pos_ff);
   assign len_s = $signed(POS_WIDTH'(len_ff));

   always_comb begin
      clamp_e = pos_s;
      if (item_ff.back_stop) begin
         clamp_e = '0;
      end
      if (item_ff.front_stop) begin
         clamp_e = len_s;
      end
      if (clamp_e < 16'sd0) begin
         clamp_e = '0;
      end else if (clamp_e > len_s) begin
         clamp_e = len_s;
      end
   end

   assign pct_src = hold ? pos_s : clamp_e;

   // percent: multiply, then one quotient bit per cycle
   logic [PROD_WIDTH-1:0] product, div_shift;
   logic                  div_take;

   assign product   = PROD_WIDTH'(e_ff) * PROD_WIDTH'(PCT_FULL);
   assign div_shift = PROD_WIDTH'(len_ff) << cnt_ff;
   assign div_take  = (rem_ff >= div_shift);

   // stroke update
   logic [PCT_WIDTH-1:0] pct_v;
   logic                 enable;
   logic signed [7:0]    sdiff;
   logic [PCT_WIDTH-1:0] adiff;
   logic                 over;
   logic [31:0]          dl_gap;
   logic                 expired;
   mode_type             upd_mode, upd_prior;
   logic                 upd_dir;
   logic [PCT_WIDTH-1:0] upd_start;
   logic [31:0]          upd_deadline;
   valve_type            upd_cmd;

   assign pct_v   = zero_ff ? '0 : (full_ff ? PCT_FULL : quo_ff);
   assign enable  = ignore_ff | (~item_ff.brake_on & ~item_ff.shift_on);
   assign sdiff   = $signed({1'b0, pct_v}) - $signed({1'b0, start_ff});
   assign adiff   = sdiff[7] ? PCT_WIDTH'(8'sd0 - sdiff) : sdiff[PCT_WIDTH-1:0];
   assign over    = (item_ff.fill_percent <= adiff)
                  | (item_ff.back_stop & ~dir_ff)
                  | (item_ff.front_stop & dir_ff);
   assign dl_gap  = item_ff.now_ms - deadline_ff;
   assign expired = ~dl_gap[31];

   always_comb begin
      upd_mode     = mode_ff;
      upd_prior    = prior_ff;
      upd_dir      = dir_ff;
      upd_start    = start_ff;
      upd_deadline = deadline_ff;
      upd_cmd      = VALVE_CLOSE;
      if (hold) begin
         upd_cmd = VALVE_HOLD;
      end else if (init_path_ff) begin
         upd_start = pct_v;
         if (!item_ff.throttle_on || !enable || mode_ff == MODE_IDLE) begin
            upd_cmd = VALVE_CLOSE;
         end else begin
            upd_cmd = dir_ff ? VALVE_FRONT : VALVE_BACK;
         end
      end else if (!enable) begin
         upd_mode = MODE_IDLE;
      end else begin
         case (mode_ff)
            MODE_IDLE: begin
               if (item_ff.throttle_on) begin
                  upd_mode = MODE_MOVE;
               end
            end
            MODE_MOVE: begin
               if (over) begin
                  if (item_ff.dead_ms == '0) begin
                     if (item_ff.throttle_on) begin
                        upd_start = pct_v;
                        upd_dir   = ~dir_ff;
                     end else begin
                        upd_mode = MODE_IDLE;
                     end
                  end else begin
                     upd_mode = MODE_DEAD;
                  end
               end
            end
            MODE_DEAD: begin
               if (expired) begin
                  upd_mode = item_ff.throttle_on ? MODE_MOVE : MODE_IDLE;
               end
            end
            default: begin
            end
         endcase
         if (prior_ff != upd_mode) begin
            if (upd_mode == MODE_MOVE) begin
               upd_start = pct_v;
               upd_dir   = ~upd_dir;
            end else if (upd_mode == MODE_DEAD) begin
               upd_deadline = item_ff.now_ms + 32'(item_ff.dead_ms);
            end
         end
         upd_prior = upd_mode;
         case (upd_mode)
            MODE_MOVE: upd_cmd = upd_dir ? VALVE_FRONT : VALVE_BACK;
            MODE_DEAD: upd_cmd = upd_dir ? VALVE_FRONT_OUT : VALVE_BACK_OUT;
            default:   upd_cmd = VALVE_CLOSE;
         endcase
      end
   end

   // next state
   always_comb begin
      preset_len_in = preset_len_ff;
      preset_inv_in = preset_inv_ff;
      ignore_in     = ignore_ff;
      dual_in       = dual_ff;
      mode_in       = mode_ff;
      prior_in      = prior_ff;
      dir_in        = dir_ff;
      pos_in        = pos_ff;
      len_in        = len_ff;
      inv_in        = inv_ff;
      start_in      = start_ff;
      deadline_in   = deadline_ff;
      item_in       = item_ff;
      init_path_in  = init_path_ff;
      e_in          = e_ff;
      zero_in       = zero_ff;
      full_in       = full_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;

      if (cmd.load_item) begin
         item_in = req_item;
      end
      if (cmd.apply_delta) begin
         pos_in = pos_step;
      end
      if (cmd.learn_step) begin
         init_path_in = ~hold & (mode_ff == MODE_INIT);
         if (!hold && mode_ff == MODE_INIT) begin
            pos_in  = lrn_pos;
            dir_in  = lrn_dir;
            mode_in = lrn_mode;
            len_in  = lrn_len;
            inv_in  = lrn_inv;
         end
      end
      if (cmd.clamp_step) begin
         if (!hold) begin
            pos_in = $unsigned(clamp_e);
         end
         e_in    = pct_src[LEN_WIDTH-1:0];
         zero_in = (len_ff == '0) | (pct_src <= 16'sd0);
         full_in = (pct_src >= len_s);
      end
      if (cmd.mul_step) begin
         rem_in = product;
         cnt_in = DIV_CNT_WIDTH'(DIV_STEPS - 1);
      end
      if (cmd.div_step) begin
         if (div_take) begin
            rem_in = rem_ff - div_shift;
         end
         quo_in = {quo_ff[PCT_WIDTH-2:0], div_take};
         cnt_in = cnt_ff - DIV_CNT_WIDTH'(1);
      end
      if (cmd.update_step) begin
         mode_in                = upd_mode;
         prior_in               = upd_prior;
         dir_in                 = upd_dir;
         start_in               = upd_start;
         deadline_in            = upd_deadline;
         res_in.valve_cmd       = upd_cmd;
         res_in.position_pct    = pct_v;
         res_in.mode            = upd_mode;
         res_in.moving_front    = upd_dir;
         res_in.dual_out        = (upd_cmd != VALVE_CLOSE) && (upd_cmd != VALVE_HOLD)
                                  ? dual_ff : 1'b0;
         rsp_valid_in           = 1'b1;
      end

      if (csr_wr.write) begin
         case (csr_wr.index)
            REG_PRESET_LENGTH: begin
               preset_len_in = csr_wr.wdata[LEN_WIDTH-1:0];
               len_in        = csr_wr.wdata[LEN_WIDTH-1:0];
            end
            REG_PRESET_INVERT: begin
               preset_inv_in = csr_wr.wdata[0];
               inv_in        = csr_wr.wdata[0];
            end
            REG_IGNORE_INTERLOCKS: ignore_in = csr_wr.wdata[0];
            REG_DUAL_VALVES:       dual_in   = csr_wr.wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         preset_len_ff <= '0;
         preset_inv_ff <= 1'b0;
         ignore_ff     <= 1'b0;
         dual_ff       <= 1'b0;
         mode_ff       <= MODE_INIT;
         prior_ff      <= MODE_IDLE;
         dir_ff        <= 1'b0;
         pos_ff        <= '0;
         len_ff        <= '0;
         inv_ff        <= 1'b0;
         start_ff      <= '0;
         deadline_ff   <= '0;
         init_path_ff  <= 1'b0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         preset_len_ff <= preset_len_in;
         preset_inv_ff <= preset_inv_in;
         ignore_ff     <= ignore_in;
         dual_ff       <= dual_in;
         mode_ff       <= mode_in;
         prior_ff      <= prior_in;
         dir_ff        <= dir_in;
         pos_ff        <= pos_in;
         len_ff        <= len_in;
         inv_ff        <= inv_in;
         start_ff      <= start_in;
         deadline_ff   <= deadline_in;
         init_path_ff  <= init_path_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      e_ff    <= e_in;
      zero_ff <= zero_in;
      full_ff <= full_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      res_ff  <= res_in;
   end

   always_comb begin
      case (csr_rindex)
         REG_PRESET_LENGTH:     csr_rdata = CSR_DATA_WIDTH'(preset_len_ff);
         REG_PRESET_INVERT:     csr_rdata = CSR_DATA_WIDTH'(preset_inv_ff);
         REG_IGNORE_INTERLOCKS: csr_rdata = CSR_DATA_WIDTH'(ignore_ff);
         REG_DUAL_VALVES:       csr_rdata = CSR_DATA_WIDTH'(dual_ff);
         default:               csr_rdata = '0;
      endcase
   end

   assign status.div_last = (cnt_ff == '0);
   assign status.out_free = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result      = res_ff;

endmodule

>>> rtl/pneumatic_piston_valve_sequencer.sv
`timescale 1ns / 1ps
// Top level of the pneumatic piston valve sequencer: controller, datapath, APB decode.
// Depends on ppvs_pkg, ppvs_req_if, ppvs_rsp_if, ppvs_controller, ppvs_datapath.
//
//   channel  | direction | handshake              | payload
//   req_ch   | in        | valid/ready            | one control tick
//   rsp_ch   | out       | valid/ready            | valve command, percent, mode
//   csr_*    | in        | APB rd/wr, pready high | four registers at 4*i
//
// A tick passes through accept, delta, learn, clamp, multiply, seven
// divider steps (one quotient bit each) and update.
// The result sits in an output register; a new tick is accepted while it waits.
// A finished tick stalls in update while the output register is still full.
// Synchronous active-high reset returns the piston to init with length zero.
module pneumatic_piston_valve_sequencer
   import ppvs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   ppvs_req_if.sink                  req_ch,
   ppvs_rsp_if.source                rsp_ch,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   ctrl_cmd_type    ctrl_cmd;
   ctrl_status_type ctrl_status;
   item_type        req_item;
   result_type      rsp_result;
   csr_write_type   csr_wr;
   logic            rsp_valid;
   logic            req_ready;

   assign csr_pready   = 1'b1;
   assign csr_wr.write = csr_psel & csr_penable & csr_pwrite;
   assign csr_wr.index = csr_paddr[3:2];
   assign csr_wr.wdata = csr_pwdata;

   assign req_item.step_delta   = req_ch.step_delta;
   assign req_item.back_stop    = req_ch.back_stop;
   assign req_item.front_stop   = req_ch.front_stop;
   assign req_item.throttle_on  = req_ch.throttle_on;
   assign req_item.brake_on     = req_ch.brake_on;
   assign req_item.shift_on     = req_ch.shift_on;
   assign req_item.fill_percent = req_ch.fill_percent;
   assign req_item.dead_ms      = req_ch.dead_ms;
   assign req_item.now_ms       = req_ch.now_ms;
   assign req_ch.ready          = req_ready;

   ppvs_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (ctrl_status),
      .cmd       (ctrl_cmd)
   );

   ppvs_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (ctrl_cmd),
      .status     (ctrl_status),
      .req_item   (req_item),
      .csr_wr     (csr_wr),
      .csr_rindex (csr_paddr[3:2]),
      .csr_rdata  (csr_prdata),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ch.ready),
      .rsp_result (rsp_result)
   );

   assign rsp_ch.valid        = rsp_valid;
   assign rsp_ch.valve_cmd    = rsp_result.valve_cmd;
   assign rsp_ch.position_pct = rsp_result.position_pct;
   assign rsp_ch.mode         = rsp_result.mode;
   assign rsp_ch.moving_front = rsp_result.moving_front;
   assign rsp_ch.dual_out     = rsp_result.dual_out;

endmodule

>>> rtl/ppvs_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the valve sequencer, bound to the top level.
// Depends on ppvs_pkg and pneumatic_piston_valve_sequencer.
module ppvs_checker
   import ppvs_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_valve_cmd,
   input logic [6:0] rsp_position_pct,
   input logic [1:0] rsp_mode,
   input logic       rsp_dual_out
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_valve_cmd)
         && $stable(rsp_position_pct) && $stable(rsp_mode))
      else $error("stalled result changed");

   a_one_tick: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second tick accepted while one is in work");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_position_pct <= PCT_FULL)
      else $error("position percent above full");

   a_dead_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_valve_cmd == VALVE_BACK_OUT || rsp_valve_cmd == VALVE_FRONT_OUT)
         |-> rsp_mode == MODE_DEAD)
      else $error("dead point valve command outside dead point mode");

   a_dual: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dual_out |-> rsp_valve_cmd != VALVE_CLOSE
         && rsp_valve_cmd != VALVE_HOLD)
      else $error("dual flag on close or hold");

endmodule

bind pneumatic_piston_valve_sequencer ppvs_checker u_ppvs_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_valve_cmd    (rsp_ch.valve_cmd),
   .rsp_position_pct (rsp_ch.position_pct),
   .rsp_mode         (rsp_ch.mode),
   .rsp_dual_out     (rsp_ch.dual_out)
);

>>> dv/tb_pneumatic_piston_valve_sequencer.sv
`timescale 1ns / 1ps
// Self-checking bench for the pneumatic piston valve sequencer: directed and random
// control ticks, APB register phases, random stalls on both channels.
// Depends on ppvs_pkg, ppvs_req_if, ppvs_rsp_if and the sequencer RTL.
module tb_pneumatic_piston_valve_sequencer;
   import ppvs_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int HOLD_AT    = 480;
   localparam int HOLD_LEN   = 300;
   localparam int DRAIN_AT   = 560;

   class stroke_checker;
      logic [14:0] preset_len;
      bit          preset_inv;
      bit          no_interlock;
      bit          dual;
      mode_type    mode_q;
      mode_type    prior_q;
      bit          dir_front;
      logic [15:0] position;
      logic [14:0] len;
      bit          inv;
      logic [6:0]  start_pct;
      logic [31:0] deadline;
      result_type  pending_commands[$];
      int          mismatches;
      int          checked;
      int          mode_hits[4];
      int          hold_hits;

      function new();
         preset_len   = '0;
         preset_inv   = 1'b0;
         no_interlock = 1'b0;
         dual         = 1'b0;
         mode_q       = MODE_INIT;
         prior_q      = MODE_IDLE;
         dir_front    = 1'b0;
         position     = '0;
         len          = '0;
         inv          = 1'b0;
         start_pct    = '0;
         deadline     = '0;
         mismatches   = 0;
         checked      = 0;
         hold_hits    = 0;
         foreach (mode_hits[i]) mode_hits[i] = 0;
      endfunction

      function void configure(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_PRESET_LENGTH: begin
               preset_len = value[14:0];
               len        = value[14:0];
            end
            REG_PRESET_INVERT: begin
               preset_inv = value[0];
               inv        = value[0];
            end
            REG_IGNORE_INTERLOCKS: no_interlock = value[0];
            REG_DUAL_VALVES:       dual = value[0];
            default: ;
         endcase
      endfunction

      function int pos_value();
         return int'($signed(position));
      endfunction

      function int percent_of(int e, int l);
         if (l == 0 || e <= 0) return 0;
         if (e >= l) return int'(PCT_FULL);
         return (e * int'(PCT_FULL)) / l;
      endfunction

      function int clamp_percent(bit back, bit front);
         int e;
         int l;
         e = pos_value();
         l = int'(len);
         if (back) e = 0;
         if (front) e = l;
         if (e < 0) e = 0;
         else if (e > l) e = l;
         position = e[15:0];
         return percent_of(e, l);
      endfunction

      function void note_tick(item_type it);
         int          d;
         int          e;
         int          l;
         int          p;
         int          pct;
         int          diff;
         bit          over;
         bit          enabled;
         logic [31:0] gap;
         valve_type   cmd;
         result_type  exp;
         d = int'(it.step_delta);
         if (inv) d = -d;
         position = position + d[15:0];
         enabled = no_interlock || (!it.brake_on && !it.shift_on);
         if (it.fill_percent == 0) begin
            e = pos_value();
            l = int'(len);
            if (e > l) e = l;
            pct = percent_of(e, l);
            cmd = VALVE_HOLD;
         end else if (mode_q == MODE_INIT) begin
            l = int'(len);
            if (it.back_stop) begin
               position = '0;
               if (l != 0) begin
                  dir_front = 1'b0;
                  mode_q = MODE_IDLE;
               end else begin
                  dir_front = 1'b1;
               end
            end
            if (it.front_stop) begin
               if (l != 0) begin
                  position = l[15:0];
                  dir_front = 1'b1;
                  mode_q = MODE_IDLE;
               end else if (dir_front) begin
                  p = pos_value();
                  if (p < 0) begin
                     inv = !inv;
                     p = -p;
                     if (p > 32767) p = 32767;
                  end
                  position = p[15:0];
                  len = p[14:0];
                  mode_q = MODE_IDLE;
               end
            end
            if (l != 0) begin
               if (mode_q == MODE_INIT) begin
                  position = 16'(l / 2);
                  dir_front = 1'b0;
               end
               mode_q = MODE_IDLE;
            end
            if (!it.throttle_on || !enabled || mode_q == MODE_IDLE) cmd = VALVE_CLOSE;
            else if (dir_front) cmd = VALVE_FRONT;
            else cmd = VALVE_BACK;
            pct = clamp_percent(it.back_stop, it.front_stop);
            start_pct = pct[6:0];
         end else begin
            pct = clamp_percent(it.back_stop, it.front_stop);
            if (!enabled) begin
               mode_q = MODE_IDLE;
               cmd = VALVE_CLOSE;
            end else begin
               diff = pct - int'(start_pct);
               if (diff < 0) diff = -diff;
               over = (int'(it.fill_percent) - diff) <= 0;
               if (it.back_stop && !dir_front) over = 1'b1;
               if (it.front_stop && dir_front) over = 1'b1;
               if (mode_q == MODE_IDLE) begin
                  if (it.throttle_on) mode_q = MODE_MOVE;
               end else if (mode_q == MODE_MOVE) begin
                  if (over) begin
                     if (it.dead_ms == 0) begin
                        if (it.throttle_on) begin
                           start_pct = pct[6:0];
                           dir_front = !dir_front;
                        end else begin
                           mode_q = MODE_IDLE;
                        end
                     end else begin
                        mode_q = MODE_DEAD;
                     end
                  end
               end else begin
                  gap = it.now_ms - deadline;
                  if (!gap[31]) mode_q = it.throttle_on ? MODE_MOVE : MODE_IDLE;
               end
               if (prior_q != mode_q) begin
                  if (mode_q == MODE_MOVE) begin
                     start_pct = pct[6:0];
                     dir_front = !dir_front;
                  end else if (mode_q == MODE_DEAD) begin
                     deadline = it.now_ms + 32'(it.dead_ms);
                  end
               end
               prior_q = mode_q;
               if (mode_q == MODE_MOVE) cmd = dir_front ? VALVE_FRONT : VALVE_BACK;
               else if (mode_q == MODE_DEAD) cmd = dir_front ? VALVE_FRONT_OUT : VALVE_BACK_OUT;
               else cmd = VALVE_CLOSE;
            end
         end
         exp.valve_cmd    = cmd;
         exp.position_pct = pct[6:0];
         exp.mode         = mode_q;
         exp.moving_front = dir_front;
         exp.dual_out     = (cmd != VALVE_CLOSE && cmd != VALVE_HOLD) ? dual : 1'b0;
         mode_hits[mode_q]++;
         if (cmd == VALVE_HOLD) hold_hits++;
         pending_commands.push_back(exp);
      endfunction

      function void check_command(result_type got);
         result_type exp;
         if (pending_commands.size() == 0) begin
            $error("valve command transfer with no tick pending");
            mismatches++;
            return;
         end
         exp = pending_commands.pop_front();
         checked++;
         if (got.valve_cmd !== exp.valve_cmd) begin
            $error("valve_cmd: expected %0d, got %0d", exp.valve_cmd, got.valve_cmd);
            mismatches++;
         end
         if (got.position_pct !== exp.position_pct) begin
            $error("position_pct: expected %0d, got %0d", exp.position_pct, got.position_pct);
            mismatches++;
         end
         if (got.mode !== exp.mode) begin
            $error("mode: expected %0d, got %0d", exp.mode, got.mode);
            mismatches++;
         end
         if (got.moving_front !== exp.moving_front) begin
            $error("moving_front: expected %0d, got %0d", exp.moving_front, got.moving_front);
            mismatches++;
         end
         if (got.dual_out !== exp.dual_out) begin
            $error("dual_out: expected %0d, got %0d", exp.dual_out, got.dual_out);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   ppvs_req_if req_ch ();
   ppvs_rsp_if rsp_ch ();

   pneumatic_piston_valve_sequencer dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   stroke_checker sb = new();
   logic [31:0]   clock_ms;
   int            sent_total = 0;
   int            idle_cycles = 0;
   bit            tx_steady = 1'b0;
   bit            rx_steady = 1'b0;
   item_type      seen_tick;
   result_type    seen_cmd;

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            seen_tick.step_delta   = req_ch.step_delta;
            seen_tick.back_stop    = req_ch.back_stop;
            seen_tick.front_stop   = req_ch.front_stop;
            seen_tick.throttle_on  = req_ch.throttle_on;
            seen_tick.brake_on     = req_ch.brake_on;
            seen_tick.shift_on     = req_ch.shift_on;
            seen_tick.fill_percent = req_ch.fill_percent;
            seen_tick.dead_ms      = req_ch.dead_ms;
            seen_tick.now_ms       = req_ch.now_ms;
            sb.note_tick(seen_tick);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen_cmd.valve_cmd    = valve_type'(rsp_ch.valve_cmd);
            seen_cmd.position_pct = rsp_ch.position_pct;
            seen_cmd.mode         = mode_type'(rsp_ch.mode);
            seen_cmd.moving_front = rsp_ch.moving_front;
            seen_cmd.dual_out     = rsp_ch.dual_out;
            sb.check_command(seen_cmd);
         end
      end
   end

   // watchdog: cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("pneumatic_piston_valve_sequencer test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : command_sink
      int gap;
      int rx_count;
      rx_count = 0;
      rsp_ch.ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
         gap = rx_steady ? 0 : $urandom_range(0, 15);
         if (rx_count == HOLD_AT) gap = HOLD_LEN;
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         rx_count++;
         @(negedge clock);
      end
   end

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      csr_pwrite  <= 1'b1;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.configure(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_tick(input item_type it);
      int gap;
      gap = tx_steady ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.step_delta   <= it.step_delta;
      req_ch.back_stop    <= it.back_stop;
      req_ch.front_stop   <= it.front_stop;
      req_ch.throttle_on  <= it.throttle_on;
      req_ch.brake_on     <= it.brake_on;
      req_ch.shift_on     <= it.shift_on;
      req_ch.fill_percent <= it.fill_percent;
      req_ch.dead_ms      <= it.dead_ms;
      req_ch.now_ms       <= it.now_ms;
      do @(posedge clock); while (!req_ch.ready);
      sent_total++;
      @(negedge clock);
   endtask

   // drain the block before touching registers
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (sb.pending_commands.size() != 0);
      repeat (20) @(negedge clock);
   endtask

   // step is the raw encoder count; advance moves the millisecond clock
   function automatic item_type tick(int step, bit back, bit front, bit thr, bit brk,
                                     bit shf, int fill, int dead, int advance);
      item_type it;
      clock_ms = clock_ms + advance;
      it.step_delta   = step[7:0];
      it.back_stop    = back;
      it.front_stop   = front;
      it.throttle_on  = thr;
      it.brake_on     = brk;
      it.shift_on     = shf;
      it.fill_percent = fill[6:0];
      it.dead_ms      = dead[7:0];
      it.now_ms       = clock_ms;
      return it;
   endfunction

   // piston-like motion: steps follow the current direction, stops near the ends
   function automatic item_type random_tick();
      item_type it;
      int       l;
      int       cap;
      int       d;
      int       nxt;
      int       r;
      l = int'(sb.len);
      r = $urandom_range(0, 99);
      if (r < 5) it.fill_percent = 7'd0;
      else if (r < 10) it.fill_percent = 7'($urandom_range(101, 127));
      else if (r < 75) it.fill_percent = 7'($urandom_range(1, 20));
      else it.fill_percent = 7'($urandom_range(21, 100));
      cap = l / 4 + 2;
      if (cap > 127) cap = 127;
      if ($urandom_range(0, 9) == 0) begin
         d = $urandom_range(0, 255) - 128;
         nxt = sb.pos_value() + (sb.inv ? -d : d);
      end else begin
         d = $urandom_range(0, cap);
         if (!sb.dir_front) d = -d;
         if (sb.mode_q != MODE_MOVE && $urandom_range(0, 1) == 0) d = 0;
         nxt = sb.pos_value() + d;
         if (sb.inv) d = -d;
      end
      it.step_delta  = d[7:0];
      it.back_stop   = (nxt <= 0 && $urandom_range(0, 3) != 0) || $urandom_range(0, 39) == 0;
      it.front_stop  = (nxt >= l && $urandom_range(0, 3) != 0) || $urandom_range(0, 39) == 0;
      it.throttle_on = $urandom_range(0, 9) != 0;
      it.brake_on    = $urandom_range(0, 19) == 0;
      it.shift_on    = $urandom_range(0, 19) == 0;
      r = $urandom_range(0, 99);
      if (r < 15) it.dead_ms = 8'd0;
      else if (r < 80) it.dead_ms = 8'($urandom_range(1, 20));
      else it.dead_ms = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
      else clock_ms = clock_ms + $urandom_range(0, 8);
      it.now_ms = clock_ms;
      return it;
   endfunction

   task automatic run_random(input int count);
      int k;
      for (k = 0; k < count; k++) begin
         if (sent_total == DRAIN_AT) begin
            req_ch.valid <= 1'b0;
            while (sb.pending_commands.size() != 0) @(negedge clock);
            @(negedge clock);
         end
         if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
         send_tick(random_tick());
      end
   endtask

   initial begin : stimulus
      int failures;
      reset               = 1'b1;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      req_ch.valid        = 1'b0;
      req_ch.step_delta   = '0;
      req_ch.back_stop    = 1'b0;
      req_ch.front_stop   = 1'b0;
      req_ch.throttle_on  = 1'b0;
      req_ch.brake_on     = 1'b0;
      req_ch.shift_on     = 1'b0;
      req_ch.fill_percent = '0;
      req_ch.dead_ms      = '0;
      req_ch.now_ms       = '0;
      clock_ms            = $urandom_range(0, 1000);
      repeat (3) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      write_csr(REG_PRESET_LENGTH, 32'd0);
      write_csr(REG_PRESET_INVERT, 32'd0);
      write_csr(REG_IGNORE_INTERLOCKS, 32'd0);
      write_csr(REG_DUAL_VALVES, 32'd0);

      // learning from the endstops, then one full stroke cycle
      send_tick(tick(127, 0, 0, 0, 0, 0, 0, 0, 1));
      send_tick(tick(-128, 0, 0, 1, 0, 0, 0, 0, 1));
      send_tick(tick(0, 0, 1, 1, 0, 0, 50, 0, 1));
      send_tick(tick(5, 1, 0, 1, 1, 0, 50, 0, 1));
      send_tick(tick(-100, 0, 0, 1, 0, 1, 50, 0, 1));
      send_tick(tick(-100, 0, 0, 1, 0, 0, 50, 0, 1));
      send_tick(tick(-100, 0, 0, 0, 0, 0, 50, 0, 1));
      send_tick(tick(0, 0, 1, 1, 0, 0, 50, 0, 1));
      send_tick(tick(50, 0, 0, 1, 0, 0, 0, 0, 1));
      send_tick(tick(0, 0, 0, 0, 0, 0, 100, 0, 1));
      send_tick(tick(0, 0, 0, 1, 0, 0, 10, 5, 1));
      send_tick(tick(40, 0, 0, 1, 0, 0, 10, 5, 1));
      send_tick(tick(0, 0, 0, 1, 0, 0, 10, 5, 2));
      send_tick(tick(0, 0, 0, 1, 0, 0, 10, 5, 4));
      send_tick(tick(-127, 0, 0, 1, 0, 0, 10, 0, 1));
      send_tick(tick(127, 0, 0, 0, 0, 0, 10, 0, 1));
      send_tick(tick(0, 1, 1, 1, 0, 0, 127, 255, 1));
      clock_ms = 32'hFFFF_FF80;
      send_tick(tick(0, 0, 1, 1, 0, 0, 127, 255, 0));
      send_tick(tick(0, 0, 0, 1, 0, 0, 127, 255, 100));
      send_tick(tick(0, 0, 0, 1, 0, 0, 127, 255, 200));
      send_tick(tick(-128, 0, 0, 1, 0, 0, 1, 0, 1));
      send_tick(tick(0, 1, 0, 1, 1, 0, 1, 0, 1));
      run_random(160);

      settle();
      write_csr(REG_PRESET_LENGTH, 32'd32767);
      write_csr(REG_PRESET_INVERT, 32'd1);
      write_csr(REG_IGNORE_INTERLOCKS, 32'd1);
      write_csr(REG_DUAL_VALVES, 32'd1);
      run_random(80);

      settle();
      write_csr(REG_PRESET_LENGTH, 32'd1);
      write_csr(REG_PRESET_INVERT, 32'd0);
      write_csr(REG_IGNORE_INTERLOCKS, 32'd0);
      run_random(80);

      settle();
      write_csr(REG_PRESET_LENGTH, 32'd0);
      write_csr(REG_IGNORE_INTERLOCKS, 32'd1);
      write_csr(REG_DUAL_VALVES, 32'd0);
      run_random(40);

      settle();
      write_csr(REG_PRESET_LENGTH, $urandom_range(50, 2000));
      write_csr(REG_PRESET_INVERT, $urandom_range(0, 1));
      write_csr(REG_IGNORE_INTERLOCKS, 32'd0);
      write_csr(REG_DUAL_VALVES, $urandom_range(0, 1));
      run_random(260);

      settle();
      failures = sb.mismatches + sb.pending_commands.size();
      $display("Checked %0d valve commands from %0d ticks over five register settings.",
               sb.checked, sent_total);
      $display("Modes predicted: init %0d, idle %0d, deadpoint %0d, move %0d; hold ticks %0d.",
               sb.mode_hits[MODE_INIT], sb.mode_hits[MODE_IDLE], sb.mode_hits[MODE_DEAD],
               sb.mode_hits[MODE_MOVE], sb.hold_hits);
      if (failures == 0) begin
         $display("pneumatic_piston_valve_sequencer test passed");
      end else begin
         $display("pneumatic_piston_valve_sequencer test failed");
      end
      $finish;
   end

endmodule
